// ----- rtl/core/vrl_pkg.sv -----
// Shared types, codes and helpers of the variable-length record log ring.
package vrl_pkg;

  localparam int unsigned HdrBytes     = 16;
  localparam int unsigned TruncMarkLen = 11;

  localparam logic [0:0] FUNC_STORE = 1'b0;
  localparam logic [0:0] FUNC_READ  = 1'b1;

  localparam logic [0:0] CFG_DEFAULT_LEVEL = 1'b0;
  localparam logic [0:0] CFG_SUPPRESS      = 1'b1;

  localparam logic [2:0] ST_STORED     = 3'd0;
  localparam logic [2:0] ST_TRUNCATED  = 3'd1;
  localparam logic [2:0] ST_NO_SPACE   = 3'd2;
  localparam logic [2:0] ST_EMPTY_CONT = 3'd3;
  localparam logic [2:0] ST_SUPPRESSED = 3'd4;
  localparam logic [2:0] ST_READ       = 3'd5;
  localparam logic [2:0] ST_NOTHING    = 3'd6;

  typedef enum logic [3:0] {
    S_IDLE,
    S_MAKE,
    S_PLACE,
    S_WRITE,
    S_RD0,
    S_RD1,
    S_F0,
    S_F1,
    S_F2,
    S_OUT
  } state_e;

  typedef struct packed {
    logic [2:0]  status;
    logic [13:0] offset;
    logic [14:0] record_len;
    logic [9:0]  text_bytes;
    logic [9:0]  dict_bytes;
    logic [7:0]  facility;
    logic [2:0]  level;
    logic [4:0]  flags;
    logic [63:0] seq;
    logic [63:0] dropped;
    logic        wrap;
  } res_t;

  function automatic res_t fill_hdr(input res_t r, input logic [63:0] h);
    res_t o;
    o            = r;
    o.record_len = h[14:0];
    o.text_bytes = h[25:16];
    o.dict_bytes = h[41:32];
    o.facility   = h[55:48];
    o.flags      = h[60:56];
    o.level      = h[63:61];
    return o;
  endfunction

endpackage

// ----- rtl/core/vrl_hdr_ram.sv -----
// Header word memory: one write port, one registered read port.
module vrl_hdr_ram #(
  parameter int unsigned AW = 11
) (
  input  logic          clk_i,
  input  logic          we_i,
  input  logic [AW-1:0] waddr_i,
  input  logic [63:0]   wdata_i,
  input  logic [AW-1:0] raddr_i,
  output logic [63:0]   rdata_o
);

  logic [63:0] mem_q [2**AW];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  always_ff @(posedge clk_i) begin
    rdata_o <= mem_q[raddr_i];
  end

endmodule

// ----- rtl/core/vrl_space.sv -----
// Free-space check: contiguous free run against record size plus a spare header.
module vrl_space #(
  parameter int unsigned BUF_BYTES = 16384,
  parameter int unsigned OFF_W     = 15,
  parameter int unsigned SZ_W      = 16
) (
  input  logic [OFF_W-1:0] write_off_i,
  input  logic [OFF_W-1:0] oldest_off_i,
  input  logic [SZ_W-1:0]  size_i,
  input  logic             empty_i,
  output logic             ok_o
);
  import vrl_pkg::*;

  logic [OFF_W-1:0] tail;
  logic [OFF_W-1:0] free_b;
  logic [SZ_W:0]    need;

  always_comb begin
    tail = OFF_W'(BUF_BYTES) - write_off_i;
    if (write_off_i > oldest_off_i || empty_i) begin
      free_b = (tail > oldest_off_i) ? tail : oldest_off_i;
    end else begin
      free_b = oldest_off_i - write_off_i;
    end
    need = (SZ_W+1)'(size_i) + (SZ_W+1)'(HdrBytes);
    ok_o = (SZ_W+1)'(free_b) >= need;
  end

endmodule

// ----- rtl/core/variable_record_log_ring_core.sv -----
// Top level: sequencer of the variable-length record log ring.
// Order: suppressed or empty stores go to S_OUT; a store runs S_MAKE, S_PLACE, S_WRITE;
// a read runs S_RD0, S_RD1 and the fetch states; then the result waits for out_ready_i.
// Throughput: one item at a time; the header memory read port and the free-space unit
// are reused on every step of the drop walk.
// Reset: all pointers and sequence numbers clear to zero, default level 4, suppress off;
// header memory needs no clearing.
module variable_record_log_ring_core #(
  parameter int unsigned LOG_BUF_BYTES = 16384,
  parameter int unsigned MAX_TAKE_PART = 4
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_ready_o,
  input  logic        func_i,
  input  logic [9:0]  text_len_i,
  input  logic [9:0]  dict_len_i,
  input  logic [7:0]  facility_i,
  input  logic signed [3:0] level_i,
  input  logic [4:0]  flags_i,
  output logic        out_valid_o,
  input  logic        out_ready_i,
  output logic [2:0]  status_o,
  output logic [13:0] offset_o,
  output logic [14:0] record_len_o,
  output logic [9:0]  text_len_out_o,
  output logic [9:0]  dict_len_out_o,
  output logic [7:0]  facility_out_o,
  output logic [2:0]  level_out_o,
  output logic [4:0]  flags_out_o,
  output logic [63:0] seq_o,
  output logic [63:0] dropped_o,
  output logic        wrap_written_o,
  input  logic        cfg_valid_i,
  output logic        cfg_ready_o,
  input  logic [0:0]  cfg_index_i,
  input  logic [2:0]  cfg_data_i
);
  import vrl_pkg::*;

  localparam int unsigned OFF_W = $clog2(LOG_BUF_BYTES) + 1;
  localparam int unsigned AW    = $clog2(LOG_BUF_BYTES / 8);
  localparam int unsigned SZ_W  = ((OFF_W > 12) ? OFF_W : 12) + 1;
  localparam int unsigned PW    = SZ_W + 2;
  localparam int unsigned CAP   = LOG_BUF_BYTES / MAX_TAKE_PART;

  state_e           state_q, state_d;
  res_t             res_q, res_d;
  logic [2:0]       dlev_q, dlev_d;
  logic             supp_q, supp_d;
  logic [OFF_W-1:0] oldest_off_q, oldest_off_d;
  logic [OFF_W-1:0] write_off_q, write_off_d;
  logic [OFF_W-1:0] reader_off_q, reader_off_d;
  logic [63:0]      oldest_seq_q, oldest_seq_d;
  logic [63:0]      write_seq_q, write_seq_d;
  logic [63:0]      reader_seq_q, reader_seq_d;
  logic [63:0]      lost_q, lost_d;
  logic             func_q, func_d;
  logic [SZ_W-1:0]  text_q, text_d;
  logic [9:0]       dict_q, dict_d;
  logic [7:0]       fac_q, fac_d;
  logic [2:0]       lvl_q, lvl_d;
  logic [4:0]       flg_q, flg_d;
  logic [SZ_W-1:0]  size_q, size_d;
  logic             trunc_q, trunc_d;
  logic             wrap_q, wrap_d;
  logic [OFF_W-1:0] f_off_q, f_off_d;

  logic             ram_we;
  logic [AW-1:0]    ram_waddr, ram_raddr;
  logic [63:0]      ram_wdata, ram_rdata;
  logic             space_ok;
  logic             seq_eq;
  logic [63:0]      hdr;
  logic [OFF_W-1:0] at_cur, nxt_off;
  logic             fetch_done;
  logic [SZ_W-1:0]  sz_new, text_cut, sz_cut;
  res_t             res_zero;

  assign seq_eq = (oldest_seq_q == write_seq_q);

  vrl_hdr_ram #(.AW(AW)) u_ram (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ram_waddr),
    .wdata_i (ram_wdata),
    .raddr_i (ram_raddr),
    .rdata_o (ram_rdata)
  );

  vrl_space #(.BUF_BYTES(LOG_BUF_BYTES), .OFF_W(OFF_W), .SZ_W(SZ_W)) u_space (
    .write_off_i  (write_off_q),
    .oldest_off_i (oldest_off_q),
    .size_i       (size_q),
    .empty_i      (seq_eq),
    .ok_o         (space_ok)
  );

  assign hdr = {lvl_q, flg_q, fac_q, 6'd0, dict_q, 16'(text_q), 16'(size_q)};
  assign ram_raddr = (state_q == S_F1) ? '0 : f_off_q[AW+2:3];

  always_comb begin
    sz_new   = (SZ_W'(HdrBytes + 7) + SZ_W'(text_len_i) + SZ_W'(dict_len_i)) & ~SZ_W'(7);
    text_cut = ((text_q > SZ_W'(CAP)) ? SZ_W'(CAP) : text_q) + SZ_W'(TruncMarkLen);
    sz_cut   = (SZ_W'(HdrBytes + 7) + text_cut) & ~SZ_W'(7);
    at_cur   = (state_q == S_F2) ? '0 : f_off_q;
    nxt_off  = OFF_W'(at_cur + OFF_W'(ram_rdata[15:0]));
    fetch_done = (state_q == S_F2) || (state_q == S_F1 && ram_rdata[15:0] != 16'd0);
    res_zero = '0;
  end

  always_comb begin
    state_d      = state_q;
    res_d        = res_q;
    dlev_d       = dlev_q;
    supp_d       = supp_q;
    oldest_off_d = oldest_off_q;
    write_off_d  = write_off_q;
    reader_off_d = reader_off_q;
    oldest_seq_d = oldest_seq_q;
    write_seq_d  = write_seq_q;
    reader_seq_d = reader_seq_q;
    lost_d       = lost_q;
    func_d       = func_q;
    text_d       = text_q;
    dict_d       = dict_q;
    fac_d        = fac_q;
    lvl_d        = lvl_q;
    flg_d        = flg_q;
    size_d       = size_q;
    trunc_d      = trunc_q;
    wrap_d       = wrap_q;
    f_off_d      = f_off_q;
    ram_we       = 1'b0;
    ram_waddr    = write_off_q[AW+2:3];
    ram_wdata    = hdr;

    if (cfg_valid_i) begin
      unique case (cfg_index_i)
        CFG_DEFAULT_LEVEL: dlev_d = cfg_data_i;
        CFG_SUPPRESS:      supp_d = cfg_data_i[0];
        default:           ;
      endcase
    end

    unique case (state_q)
      S_IDLE: begin
        if (in_valid_i) begin
          func_d  = func_i;
          res_d   = res_zero;
          lost_d  = '0;
          trunc_d = 1'b0;
          wrap_d  = 1'b0;
          if (func_i == FUNC_READ) begin
            state_d = S_RD0;
          end else if (supp_q) begin
            res_d.status = ST_SUPPRESSED;
            state_d      = S_OUT;
          end else if (text_len_i == 10'd0 && flags_i[3]) begin
            res_d.status = ST_EMPTY_CONT;
            state_d      = S_OUT;
          end else begin
            text_d  = SZ_W'(text_len_i);
            dict_d  = dict_len_i;
            fac_d   = facility_i;
            flg_d   = flags_i;
            lvl_d   = (level_i == -4'sd1) ? dlev_q : level_i[2:0];
            size_d  = sz_new;
            state_d = S_MAKE;
          end
        end
      end
      S_MAKE: begin
        if (!seq_eq && !space_ok) begin
          f_off_d = oldest_off_q;
          state_d = S_F0;
        end else if (space_ok) begin
          state_d = S_PLACE;
        end else if (!trunc_q) begin
          text_d  = text_cut;
          dict_d  = '0;
          size_d  = sz_cut;
          trunc_d = 1'b1;
        end else begin
          res_d.status = ST_NO_SPACE;
          state_d      = S_OUT;
        end
      end
      S_PLACE: begin
        if (PW'(write_off_q) + PW'(size_q) + PW'(HdrBytes) > PW'(LOG_BUF_BYTES)) begin
          ram_we      = 1'b1;
          ram_wdata   = '0;
          write_off_d = '0;
          wrap_d      = 1'b1;
        end
        state_d = S_WRITE;
      end
      S_WRITE: begin
        ram_we       = 1'b1;
        res_d        = fill_hdr(res_zero, hdr);
        res_d.status = trunc_q ? ST_TRUNCATED : ST_STORED;
        res_d.offset = 14'(write_off_q);
        res_d.seq    = write_seq_q;
        res_d.wrap   = wrap_q;
        write_off_d  = OFF_W'(write_off_q + OFF_W'(size_q));
        write_seq_d  = write_seq_q + 64'd1;
        state_d      = S_OUT;
      end
      S_RD0: begin
        if (reader_seq_q < oldest_seq_q) begin
          lost_d       = oldest_seq_q - reader_seq_q;
          reader_seq_d = oldest_seq_q;
          reader_off_d = oldest_off_q;
        end
        state_d = S_RD1;
      end
      S_RD1: begin
        if (reader_seq_q == write_seq_q) begin
          res_d.status  = ST_NOTHING;
          res_d.seq     = reader_seq_q;
          res_d.dropped = lost_q;
          state_d       = S_OUT;
        end else begin
          f_off_d = reader_off_q;
          state_d = S_F0;
        end
      end
      S_F0: begin
        state_d = S_F1;
      end
      S_F1, S_F2: begin
        if (!fetch_done) begin
          state_d = S_F2;
        end else if (func_q == FUNC_READ) begin
          res_d         = fill_hdr(res_zero, ram_rdata);
          res_d.status  = ST_READ;
          res_d.offset  = 14'(at_cur);
          res_d.seq     = reader_seq_q;
          res_d.dropped = lost_q;
          reader_off_d  = nxt_off;
          reader_seq_d  = reader_seq_q + 64'd1;
          state_d       = S_OUT;
        end else begin
          oldest_off_d = nxt_off;
          oldest_seq_d = oldest_seq_q + 64'd1;
          state_d      = S_MAKE;
        end
      end
      S_OUT: begin
        if (out_ready_i) begin
          state_d = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= S_IDLE;
      dlev_q       <= 3'd4;
      supp_q       <= 1'b0;
      oldest_off_q <= '0;
      write_off_q  <= '0;
      reader_off_q <= '0;
      oldest_seq_q <= '0;
      write_seq_q  <= '0;
      reader_seq_q <= '0;
    end else begin
      state_q      <= state_d;
      dlev_q       <= dlev_d;
      supp_q       <= supp_d;
      oldest_off_q <= oldest_off_d;
      write_off_q  <= write_off_d;
      reader_off_q <= reader_off_d;
      oldest_seq_q <= oldest_seq_d;
      write_seq_q  <= write_seq_d;
      reader_seq_q <= reader_seq_d;
    end
  end

  always_ff @(posedge clk_i) begin
    res_q   <= res_d;
    lost_q  <= lost_d;
    func_q  <= func_d;
    text_q  <= text_d;
    dict_q  <= dict_d;
    fac_q   <= fac_d;
    lvl_q   <= lvl_d;
    flg_q   <= flg_d;
    size_q  <= size_d;
    trunc_q <= trunc_d;
    wrap_q  <= wrap_d;
    f_off_q <= f_off_d;
  end

  assign in_ready_o     = (state_q == S_IDLE);
  assign out_valid_o    = (state_q == S_OUT);
  assign cfg_ready_o    = 1'b1;
  assign status_o       = res_q.status;
  assign offset_o       = res_q.offset;
  assign record_len_o   = res_q.record_len;
  assign text_len_out_o = res_q.text_bytes;
  assign dict_len_out_o = res_q.dict_bytes;
  assign facility_out_o = res_q.facility;
  assign level_out_o    = res_q.level;
  assign flags_out_o    = res_q.flags;
  assign seq_o          = res_q.seq;
  assign dropped_o      = res_q.dropped;
  assign wrap_written_o = res_q.wrap;

endmodule

// ----- tb/sv/vrl_ring_checker.sv -----
// Checker of the log ring: watches every channel, predicts each result and compares it.
module vrl_ring_checker (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  input  logic        in_ready_i,
  input  logic        func_i,
  input  logic [9:0]  text_len_i,
  input  logic [9:0]  dict_len_i,
  input  logic [7:0]  facility_i,
  input  logic [3:0]  level_i,
  input  logic [4:0]  flags_i,
  input  logic        out_valid_i,
  input  logic        out_ready_i,
  input  logic [2:0]  status_i,
  input  logic [13:0] offset_i,
  input  logic [14:0] record_len_i,
  input  logic [9:0]  text_len_out_i,
  input  logic [9:0]  dict_len_out_i,
  input  logic [7:0]  facility_out_i,
  input  logic [2:0]  level_out_i,
  input  logic [4:0]  flags_out_i,
  input  logic [63:0] seq_i,
  input  logic [63:0] dropped_i,
  input  logic        wrap_written_i,
  input  logic        cfg_valid_i,
  input  logic        cfg_ready_i,
  input  logic [0:0]  cfg_index_i,
  input  logic [2:0]  cfg_data_i,
  output int          fail_count_o
);
  timeunit 1ns;
  timeprecision 1ps;
  import vrl_pkg::*;

  localparam int unsigned RingBytes = 16384;
  localparam int unsigned TakePart  = 4;
  localparam int unsigned RingWords = RingBytes / 8;

  logic [63:0]     hdr_mem [RingWords];
  int unsigned     oldest_off, write_off, reader_off;
  longint unsigned oldest_sq, write_sq, reader_sq;
  logic [2:0]      dflt_level;
  logic            suppress_on;
  res_t            ring_results [$];

  function automatic logic [63:0] hdr_at(int unsigned off);
    if ((off >> 3) >= RingWords) return '0;
    return hdr_mem[off >> 3];
  endfunction

  function automatic int unsigned after_rec(int unsigned off);
    int unsigned len;
    len = 32'(hdr_at(off) & 64'hFFFF);
    if (len == 0) return 32'(hdr_at(0) & 64'hFFFF);
    return off + len;
  endfunction

  function automatic int unsigned rec_size(int unsigned txt, int unsigned dct);
    return (HdrBytes + txt + dct + 7) & ~32'd7;
  endfunction

  function automatic bit room_for(int unsigned size, bit empty);
    int unsigned tail, free_b;
    if (write_off > oldest_off || empty) begin
      tail   = (write_off <= RingBytes) ? RingBytes - write_off : 0;
      free_b = (tail > oldest_off) ? tail : oldest_off;
    end else begin
      free_b = oldest_off - write_off;
    end
    return free_b >= size + HdrBytes;
  endfunction

  function automatic bit free_up(int unsigned size);
    while (oldest_sq < write_sq && !room_for(size, 1'b0)) begin
      oldest_off = after_rec(oldest_off);
      oldest_sq++;
    end
    return room_for(size, oldest_sq == write_sq);
  endfunction

  function automatic res_t unpack_hdr(res_t r, logic [63:0] h);
    r.record_len = h[14:0];
    r.text_bytes = h[25:16];
    r.dict_bytes = h[41:32];
    r.facility   = h[55:48];
    r.flags      = h[60:56];
    r.level      = h[63:61];
    return r;
  endfunction

  function automatic res_t store_rec(int unsigned txt, int unsigned dct, logic [7:0] fac,
                                     logic [3:0] lvl, logic [4:0] flg);
    res_t        r;
    int unsigned size;
    logic [2:0]  lv;
    logic [63:0] h;
    bit          cut;
    r   = '0;
    cut = 1'b0;
    if (suppress_on) begin
      r.status = ST_SUPPRESSED;
      return r;
    end
    if (txt == 0 && flg[3]) begin
      r.status = ST_EMPTY_CONT;
      return r;
    end
    lv   = (lvl == 4'hF) ? dflt_level : lvl[2:0];
    size = rec_size(txt, dct);
    if (!free_up(size)) begin
      if (txt > RingBytes / TakePart) txt = RingBytes / TakePart;
      txt  = txt + TruncMarkLen;
      dct  = 0;
      cut  = 1'b1;
      size = rec_size(txt, 0);
      if (!free_up(size)) begin
        r.status = ST_NO_SPACE;
        return r;
      end
    end
    if (write_off + size + HdrBytes > RingBytes) begin
      if ((write_off >> 3) < RingWords) hdr_mem[write_off >> 3] = '0;
      write_off = 0;
      r.wrap    = 1'b1;
    end
    h = {lv, flg, fac, 16'(dct), 16'(txt), 16'(size)};
    if ((write_off >> 3) < RingWords) hdr_mem[write_off >> 3] = h;
    r.status = cut ? ST_TRUNCATED : ST_STORED;
    r.offset = write_off[13:0];
    r        = unpack_hdr(r, h);
    r.seq    = write_sq;
    write_off += size;
    write_sq++;
    return r;
  endfunction

  function automatic res_t read_rec();
    res_t        r;
    int unsigned at;
    logic [63:0] h;
    r = '0;
    if (reader_sq < oldest_sq) begin
      r.dropped  = oldest_sq - reader_sq;
      reader_sq  = oldest_sq;
      reader_off = oldest_off;
    end
    if (reader_sq == write_sq) begin
      r.status = ST_NOTHING;
      r.seq    = reader_sq;
      return r;
    end
    at = reader_off;
    h  = hdr_at(at);
    if (h[15:0] == 0) begin
      at = 0;
      h  = hdr_at(0);
    end
    r.status   = ST_READ;
    r.offset   = at[13:0];
    r          = unpack_hdr(r, h);
    r.seq      = reader_sq;
    reader_off = after_rec(reader_off);
    reader_sq++;
    return r;
  endfunction

  task automatic check_fld(string name, logic [63:0] exp_v, logic [63:0] act_v);
    if (exp_v !== act_v) begin
      $error("%s: expected %0d, got %0d", name, exp_v, act_v);
      fail_count_o++;
    end
  endtask

  initial begin
    fail_count_o = 0;
    oldest_off = 0; write_off = 0; reader_off = 0;
    oldest_sq = 0; write_sq = 0; reader_sq = 0;
    dflt_level = 3'd4;
    suppress_on = 1'b0;
    foreach (hdr_mem[i]) hdr_mem[i] = '0;
  end

  always @(posedge clk_i) begin
    res_t e;
    if (rst_ni) begin
      if (cfg_valid_i && cfg_ready_i) begin
        if (cfg_index_i == CFG_DEFAULT_LEVEL) dflt_level = cfg_data_i;
        else suppress_on = cfg_data_i[0];
      end
      if (in_valid_i && in_ready_i) begin
        if (func_i == FUNC_READ) ring_results.push_back(read_rec());
        else ring_results.push_back(store_rec(text_len_i, dict_len_i, facility_i,
                                              level_i, flags_i));
      end
      if (out_valid_i && out_ready_i) begin
        if (ring_results.size() == 0) begin
          $error("result beat with no expectation waiting");
          fail_count_o++;
        end else begin
          e = ring_results.pop_front();
          check_fld("status", e.status, status_i);
          check_fld("offset", e.offset, offset_i);
          check_fld("record_len", e.record_len, record_len_i);
          check_fld("text_len_out", e.text_bytes, text_len_out_i);
          check_fld("dict_len_out", e.dict_bytes, dict_len_out_i);
          check_fld("facility_out", e.facility, facility_out_i);
          check_fld("level_out", e.level, level_out_i);
          check_fld("flags_out", e.flags, flags_out_i);
          check_fld("seq", e.seq, seq_i);
          check_fld("dropped", e.dropped, dropped_i);
          check_fld("wrap_written", e.wrap, wrap_written_i);
        end
      end
    end
  end

endmodule

// ----- tb/sv/tb_variable_record_log_ring_core.sv -----
// Top of the log ring testbench: clock, reset, stimulus and verdict.
module tb_variable_record_log_ring_core;
  timeunit 1ns;
  timeprecision 1ps;
  import vrl_pkg::*;

  logic        clk, rst_n;
  logic        in_valid, in_ready, func;
  logic [9:0]  text_bytes, dict_bytes;
  logic [7:0]  facility;
  logic [3:0]  level;
  logic [4:0]  flags;
  logic        out_valid, out_ready;
  logic [2:0]  status;
  logic [13:0] offset;
  logic [14:0] record_len;
  logic [9:0]  text_len_out, dict_len_out;
  logic [7:0]  facility_out;
  logic [2:0]  level_out;
  logic [4:0]  flags_out;
  logic [63:0] seq, dropped;
  logic        wrap_written;
  logic        cfg_valid, cfg_ready;
  logic [0:0]  cfg_index;
  logic [2:0]  cfg_data;
  int          fail_count;
  int          beats_in, beats_out, cycles;
  bit          no_idle;

  variable_record_log_ring_core u_top (
    .clk_i(clk), .rst_ni(rst_n),
    .in_valid_i(in_valid), .in_ready_o(in_ready), .func_i(func),
    .text_len_i(text_bytes), .dict_len_i(dict_bytes), .facility_i(facility),
    .level_i(level), .flags_i(flags),
    .out_valid_o(out_valid), .out_ready_i(out_ready),
    .status_o(status), .offset_o(offset), .record_len_o(record_len),
    .text_len_out_o(text_len_out), .dict_len_out_o(dict_len_out),
    .facility_out_o(facility_out), .level_out_o(level_out), .flags_out_o(flags_out),
    .seq_o(seq), .dropped_o(dropped), .wrap_written_o(wrap_written),
    .cfg_valid_i(cfg_valid), .cfg_ready_o(cfg_ready),
    .cfg_index_i(cfg_index), .cfg_data_i(cfg_data)
  );

  vrl_ring_checker u_checker (
    .clk_i(clk), .rst_ni(rst_n),
    .in_valid_i(in_valid), .in_ready_i(in_ready), .func_i(func),
    .text_len_i(text_bytes), .dict_len_i(dict_bytes), .facility_i(facility),
    .level_i(level), .flags_i(flags),
    .out_valid_i(out_valid), .out_ready_i(out_ready),
    .status_i(status), .offset_i(offset), .record_len_i(record_len),
    .text_len_out_i(text_len_out), .dict_len_out_i(dict_len_out),
    .facility_out_i(facility_out), .level_out_i(level_out), .flags_out_i(flags_out),
    .seq_i(seq), .dropped_i(dropped), .wrap_written_i(wrap_written),
    .cfg_valid_i(cfg_valid), .cfg_ready_i(cfg_ready),
    .cfg_index_i(cfg_index), .cfg_data_i(cfg_data),
    .fail_count_o(fail_count)
  );

  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  initial begin
    cycles = 0;
    forever begin
      @(posedge clk);
      cycles++;
      if (cycles > 3000000) begin
        $display("tb_variable_record_log_ring_core NOT OK");
        $finish;
      end
    end
  end

  always @(posedge clk) begin
    if (in_valid && in_ready) beats_in++;
    if (out_valid && out_ready) beats_out++;
  end

  initial begin
    int n;
    out_ready = 1'b0;
    @(posedge rst_n);
    @(negedge clk);
    forever begin
      n = no_idle ? 0 : $urandom_range(0, 16);
      if (n > 0) begin
        out_ready <= 1'b0;
        repeat (n) @(negedge clk);
      end
      out_ready <= 1'b1;
      do @(posedge clk); while (!(out_valid && out_ready));
      @(negedge clk);
    end
  end

  task automatic send_rec(logic f, logic [9:0] t, logic [9:0] d, logic [7:0] fa,
                          logic [3:0] lv, logic [4:0] fl);
    int gap;
    gap = no_idle ? 0 : $urandom_range(0, 16);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    func <= f; text_bytes <= t; dict_bytes <= d; facility <= fa; level <= lv; flags <= fl;
    in_valid <= 1'b1;
    do @(posedge clk); while (!(in_valid && in_ready));
    @(negedge clk);
  endtask

  task automatic drain_ring();
    in_valid <= 1'b0;
    while (beats_out != beats_in) @(negedge clk);
    repeat (8) @(negedge clk);
  endtask

  task automatic write_reg(logic [0:0] idx, logic [2:0] val);
    drain_ring();
    cfg_index <= idx;
    cfg_data  <= val;
    cfg_valid <= 1'b1;
    do @(posedge clk); while (!(cfg_valid && cfg_ready));
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  task automatic rand_rec(int store_pct);
    logic [9:0] t;
    logic [4:0] fl;
    fl = 5'($urandom_range(0, 31));
    case ($urandom_range(0, 9))
      0:       t = 10'd0;
      1:       t = 10'd1023;
      2, 3, 4: t = 10'($urandom_range(0, 1023));
      default: t = 10'($urandom_range(0, 200));
    endcase
    if (t == 0 && $urandom_range(0, 3) != 0) fl[3] = 1'b0;
    if ($urandom_range(0, 99) < store_pct)
      send_rec(FUNC_STORE, t, ($urandom_range(0, 3) == 0) ? 10'($urandom_range(0, 1023))
               : 10'($urandom_range(0, 64)), 8'($urandom_range(0, 255)),
               4'($urandom_range(0, 15)), fl);
    else
      send_rec(FUNC_READ, 10'($urandom), 10'($urandom), 8'($urandom), 4'($urandom),
               5'($urandom));
  endtask

  initial begin
    in_valid = 1'b0; func = FUNC_STORE; text_bytes = '0; dict_bytes = '0;
    facility = '0; level = '0; flags = '0;
    cfg_valid = 1'b0; cfg_index = CFG_DEFAULT_LEVEL; cfg_data = '0;
    beats_in = 0; beats_out = 0; no_idle = 1'b0;
    rst_n = 1'b0;
    repeat (3) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;
    @(negedge clk);

    send_rec(FUNC_READ, '0, '0, '0, '0, '0);
    send_rec(FUNC_STORE, 10'd0, 10'd0, 8'd0, 4'hF, 5'd0);
    send_rec(FUNC_STORE, 10'd1023, 10'd1023, 8'd255, 4'd7, 5'd31);
    send_rec(FUNC_STORE, 10'd992, 10'd0, 8'd1, 4'd8, 5'd2);
    send_rec(FUNC_STORE, 10'd0, 10'd5, 8'd3, 4'd0, 5'd8);
    send_rec(FUNC_STORE, 10'd1, 10'd0, 8'd4, 4'hE, 5'd8);
    send_rec(FUNC_READ, '1, '1, '1, '1, '1);
    send_rec(FUNC_READ, '0, '0, '0, '0, '0);
    send_rec(FUNC_READ, '0, '0, '0, '0, '0);
    send_rec(FUNC_READ, '0, '0, '0, '0, '0);
    send_rec(FUNC_READ, '0, '0, '0, '0, '0);
    write_reg(CFG_DEFAULT_LEVEL, 3'd0);
    send_rec(FUNC_STORE, 10'd7, 10'd9, 8'd17, 4'hF, 5'd16);
    write_reg(CFG_DEFAULT_LEVEL, 3'd7);
    send_rec(FUNC_STORE, 10'd8, 10'd0, 8'd18, 4'hF, 5'd1);
    write_reg(CFG_SUPPRESS, 3'd1);
    send_rec(FUNC_STORE, 10'd100, 10'd100, 8'd9, 4'd3, 5'd4);
    send_rec(FUNC_READ, '0, '0, '0, '0, '0);
    write_reg(CFG_SUPPRESS, 3'd0);
    for (int i = 0; i < 14; i++)
      send_rec(FUNC_STORE, 10'd1023, 10'd1023, i[7:0], i[3:0], i[4:0]);
    send_rec(FUNC_READ, '0, '0, '0, '0, '0);

    for (int i = 0; i < 1900; i++) begin
      if (i % 250 == 0) begin
        write_reg(CFG_DEFAULT_LEVEL, 3'($urandom_range(0, 7)));
        write_reg(CFG_SUPPRESS, 3'($urandom_range(0, 3) == 0));
      end else if (i % 250 == 40) begin
        write_reg(CFG_SUPPRESS, 3'd0);
      end
      if (i % 100 == 0) no_idle = ($urandom_range(0, 3) == 0);
      rand_rec(((i / 150) % 3 == 0) ? 90 : ((i / 150) % 3 == 1) ? 30 : 60);
    end

    drain_ring();
    repeat (20) @(posedge clk);
    if (fail_count == 0) begin
      $display("tb_variable_record_log_ring_core OK");
    end else begin
      $display("tb_variable_record_log_ring_core NOT OK");
    end
    $finish;
  end

endmodule
